### src/lpe_pkg.sv
// Shared types, widths and codes of the line position estimator.
package lpe_pkg;

	// sample and position formats
	localparam int SAMPLE_BITS = 10;
	localparam int FRAC_BITS   = 14;
	localparam int NUM_SENSORS = 6;

	// derived widths
	localparam int TSUM_W = SAMPLE_BITS + 3;         // sum of six intensities
	localparam int WSUM_W = SAMPLE_BITS + 5;         // signed weighted sum, |w| <= 9 * max
	localparam int MAG_W  = SAMPLE_BITS + 4;         // magnitude of the weighted sum
	localparam int DEN_W  = TSUM_W + 3;              // five times the intensity sum
	localparam int DVD_W  = MAG_W + FRAC_BITS;       // scaled dividend
	localparam int CNT_W  = $clog2(DVD_W);
	localparam int POS_W  = FRAC_BITS + 2;           // signed position before packing

	// configuration port
	localparam int CFG_DATA_W = SAMPLE_BITS;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_MIN_ACTV = 1'd1;
	localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET     = SAMPLE_BITS'(512);
	localparam logic [2:0]             CROSSING_RESET      = 3'd5;

	// sensor weights, leftmost first
	localparam int SENSOR_WEIGHT [NUM_SENSORS] = '{-5, -3, -1, 1, 3, 5};

	// pattern codes
	localparam logic [2:0] PAT_LOST     = 3'd0;
	localparam logic [2:0] PAT_CROSSING = 3'd1;
	localparam logic [2:0] PAT_STRAIGHT = 3'd2;
	localparam logic [2:0] PAT_LIGHT    = 3'd3;
	localparam logic [2:0] PAT_MEDIUM   = 3'd4;
	localparam logic [2:0] PAT_SHARP    = 3'd5;

	// heading codes
	localparam logic [1:0] HDG_CENTER = 2'd0;
	localparam logic [1:0] HDG_LEFT   = 2'd1;
	localparam logic [1:0] HDG_RIGHT  = 2'd2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// one input item
	typedef struct packed {
		sample_t raw_0;
		sample_t raw_1;
		sample_t raw_2;
		sample_t raw_3;
		sample_t raw_4;
		sample_t raw_5;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic signed [15:0] position;
		logic [5:0]         active_mask;
		logic [2:0]         active_count;
		logic [2:0]         pattern;
		logic [1:0]         direction;
	} out_item_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic signed [WSUM_W-1:0] wsum;
		logic [TSUM_W-1:0]        tsum;
		logic [5:0]               mask;
		logic [2:0]               count;
	} job_t;

	// queue status seen by the back
	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

### src/line_position_estimator.sv
// Top level of the line position estimator: configuration, front, queue and back.
//
//  channel   ports                          accepted when
//  ------    -----------------------------  ----------------------
//  items     push, full, item               push && !full
//  results   pop, empty, result             pop && !empty
//  config    cfg_we, cfg_index, cfg_data    cfg_we
//
// With the back free, a pushed item goes into the queue, is loaded into the back,
// passes 28 steps of the bit-serial restoring divider (one quotient bit a cycle)
// and is graded into the result register; the back takes no new item until the
// last one is graded. An item with no active sensor skips the divider.
// Reset clears the queue, the direction memory (center) and both registers.
// Up to two items wait in the queue while the back works; a result not yet
// popped holds the back in its final step, and full rises once the queue fills.
module line_position_estimator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  lpe_pkg::in_item_t                   item,
	input  logic                                pop,
	output logic                                empty,
	output lpe_pkg::out_item_t                  result,
	input  logic                                cfg_we,
	input  logic [lpe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lpe_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lpe_pkg::*;

	logic [SAMPLE_BITS-1:0] line_threshold_q;
	logic [2:0]             crossing_min_active_q;
	job_t                   front_job;
	job_t                   back_job;
	queue_status_t          q_status;
	logic                   job_rd;

	assign full = q_status.full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_threshold_q      <= THRESHOLD_RESET;
			crossing_min_active_q <= CROSSING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_THRESHOLD:    line_threshold_q      <= cfg_data[SAMPLE_BITS-1:0];
				CFG_CROSSING_MIN_ACTV: crossing_min_active_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	lpe_front u_front (
		.item           (item),
		.line_threshold (line_threshold_q),
		.job            (front_job)
	);

	lpe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wr_job (front_job),
		.rd     (job_rd),
		.rd_job (back_job),
		.status (q_status)
	);

	lpe_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.q_status            (q_status),
		.job                 (back_job),
		.job_rd              (job_rd),
		.crossing_min_active (crossing_min_active_q),
		.pop                 (pop),
		.empty               (empty),
		.result              (result)
	);

endmodule

### src/lpe_front.sv
// Front end: threshold, intensity and weighted sums of one item.
module lpe_front (
	input  lpe_pkg::in_item_t                   item,
	input  logic [lpe_pkg::SAMPLE_BITS-1:0]     line_threshold,
	output lpe_pkg::job_t                       job
);
	import lpe_pkg::*;

	sample_t raw [NUM_SENSORS];

	// unpack samples, leftmost first
	always_comb begin
		raw[0] = item.raw_0;
		raw[1] = item.raw_1;
		raw[2] = item.raw_2;
		raw[3] = item.raw_3;
		raw[4] = item.raw_4;
		raw[5] = item.raw_5;
	end

	// classify each sensor and accumulate the sums
	always_comb begin
		sample_t                  inten;
		logic signed [WSUM_W-1:0] term;
		logic signed [WSUM_W-1:0] wsum;
		logic [TSUM_W-1:0]        tsum;
		logic [5:0]               mask;
		logic [2:0]               count;
		wsum  = '0;
		tsum  = '0;
		mask  = '0;
		count = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			inten = line_threshold - raw[i];
			if (inten == '0) begin
				inten = sample_t'(1);
			end
			term = WSUM_W'(SENSOR_WEIGHT[i]) * $signed({{(WSUM_W-SAMPLE_BITS){1'b0}}, inten});
			if (raw[i] <= line_threshold) begin
				mask[i] = 1'b1;
				count   = count + 3'd1;
				wsum    = wsum + term;
				tsum    = tsum + TSUM_W'(inten);
			end
		end
		job.wsum  = wsum;
		job.tsum  = tsum;
		job.mask  = mask;
		job.count = count;
	end

endmodule

### src/lpe_queue.sv
// Two-entry queue of classified items between the front and the back.
module lpe_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  lpe_pkg::job_t          wr_job,
	input  logic                   rd,
	output lpe_pkg::job_t          rd_job,
	output lpe_pkg::queue_status_t status
);
	import lpe_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_wr;
	logic       do_rd;

	assign status = '{empty: (fill_q == 2'd0), full: (fill_q == 2'd2)};
	assign do_wr  = wr && !status.full;
	assign do_rd  = rd && !status.empty;
	assign rd_job = entry_q[rd_ptr_q];

	// store written items
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

### src/lpe_back.sv
// Back end: restoring divider, direction memory, grading and result register.
module lpe_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lpe_pkg::queue_status_t q_status,
	input  lpe_pkg::job_t          job,
	output logic                   job_rd,
	input  logic [2:0]             crossing_min_active,
	input  logic                   pop,
	output logic                   empty,
	output lpe_pkg::out_item_t     result
);
	import lpe_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [FRAC_BITS:0]   ONE      = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS+4:0] ONE_W    = (FRAC_BITS+5)'(ONE);
	localparam logic [FRAC_BITS+2:0] ONE_X4   = (FRAC_BITS+3)'(ONE);
	localparam logic [FRAC_BITS+2:0] THREE_X4 = (FRAC_BITS+3)'(3) << FRAC_BITS;

	logic [1:0]         state_q;
	logic               lost_q;
	logic               neg_q;
	logic [5:0]         mask_q;
	logic [2:0]         count_q;
	logic [DEN_W-1:0]   den_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DEN_W:0]     rem_q;
	logic [DVD_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         dir_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic [MAG_W-1:0]           mag;
	logic [DEN_W:0]             rem_shift;
	logic                       rem_ge;
	logic [FRAC_BITS:0]         abs_pos;
	logic signed [POS_W-1:0]    pos;
	logic [FRAC_BITS+4:0]       abs_x10;
	logic [FRAC_BITS+2:0]       abs_x4;
	logic [FRAC_BITS+2:0]       abs_x2;
	logic [1:0]                 dir_new;
	logic [2:0]                 pat_new;
	logic                       out_free;
	logic                       finish;

	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign job_rd   = (state_q == ST_IDLE) && !q_status.empty;
	assign out_free = !out_valid_q || pop;
	assign finish   = (state_q == ST_FIN) && out_free;

	// magnitude of the incoming weighted sum
	always_comb begin
		logic signed [WSUM_W-1:0] neg_w;
		neg_w = -job.wsum;
		mag   = job.wsum[WSUM_W-1] ? MAG_W'(neg_w) : MAG_W'(job.wsum);
	end

	// one restoring division step
	assign rem_shift = {rem_q[DEN_W-1:0], dvd_q[DVD_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, den_q});

	// clamp, sign and grade the quotient
	always_comb begin
		abs_pos = (quo_q > DVD_W'(ONE)) ? ONE : quo_q[FRAC_BITS:0];
		abs_x10 = (FRAC_BITS+5)'(abs_pos) * (FRAC_BITS+5)'(10);
		abs_x4  = {abs_pos, 2'b00};
		abs_x2  = {1'b0, abs_pos, 1'b0};
		if (lost_q) begin
			unique case (dir_q)
				HDG_RIGHT: pos = POS_W'($signed({1'b0, ONE}));
				HDG_LEFT:  pos = -POS_W'($signed({1'b0, ONE}));
				default:   pos = '0;
			endcase
			dir_new = dir_q;
			pat_new = PAT_LOST;
		end else begin
			pos = neg_q ? -$signed({1'b0, abs_pos}) : $signed({1'b0, abs_pos});
			if (abs_x10 > ONE_W) begin
				dir_new = neg_q ? HDG_LEFT : HDG_RIGHT;
			end else begin
				dir_new = HDG_CENTER;
			end
			priority if (count_q >= crossing_min_active) begin
				pat_new = PAT_CROSSING;
			end else if (abs_x4 < ONE_X4) begin
				pat_new = PAT_STRAIGHT;
			end else if (abs_x2 < ONE_X4) begin
				pat_new = PAT_LIGHT;
			end else if (abs_x4 < THREE_X4) begin
				pat_new = PAT_MEDIUM;
			end else begin
				pat_new = PAT_SHARP;
			end
		end
	end

	// datapath registers of the item in work
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_rd) begin
					lost_q  <= (job.count == 3'd0);
					neg_q   <= job.wsum[WSUM_W-1];
					mask_q  <= job.mask;
					count_q <= job.count;
					den_q   <= DEN_W'(job.tsum) * DEN_W'(5);
					dvd_q   <= {mag, {FRAC_BITS{1'b0}}};
					rem_q   <= '0;
					quo_q   <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? (rem_shift - {1'b0, den_q}) : rem_shift;
				quo_q <= {quo_q[DVD_W-2:0], rem_ge};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
			default: begin
			end
		endcase
		if (finish) begin
			out_q.position     <= 16'(pos);
			out_q.active_mask  <= mask_q;
			out_q.active_count <= count_q;
			out_q.pattern      <= pat_new;
			out_q.direction    <= (dir_new == HDG_RIGHT || dir_new == HDG_LEFT) ? dir_new
				: HDG_CENTER;
		end
	end

	// sequence the item, keep direction, hold the result until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dir_q       <= HDG_CENTER;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_rd) begin
						cnt_q   <= '0;
						state_q <= (job.count == 3'd0) ? ST_FIN : ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DVD_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				dir_q       <= dir_new;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### bench/line_position_estimator_tb.sv
// Self-checking testbench of the line position estimator: directed table, then random scans.
`timescale 1ns / 100ps

module line_position_estimator_tb;
	import lpe_pkg::*;

	localparam int PERIOD_NS    = 10;
	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 40;      // a little more than one item's latency
	localparam int CYCLE_LIMIT  = 600000;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_SCANS  = 213;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_REG   = -1;      // phase table marker: pick the value at random
	localparam int NUM_ROWS     = 18;

	// per phase settings
	localparam int PHASE_THR [NUM_PHASES] = '{512, 0, 1023, 300, 700, RANDOM_REG, RANDOM_REG, 512};
	localparam int PHASE_CROSS [NUM_PHASES] = '{5, 1, 6, 0, 7, RANDOM_REG, RANDOM_REG, 3};

	// directed scans at reset settings (threshold 512, crossing 5), leftmost first
	localparam int ROW_SCAN [NUM_ROWS][NUM_SENSORS] = '{
		'{1023, 1023, 1023, 1023, 1023, 1023},
		'{0, 0, 0, 0, 0, 0},
		'{0, 1023, 1023, 1023, 1023, 1023},
		'{1023, 1023, 1023, 1023, 1023, 1023},
		'{1023, 1023, 1023, 1023, 1023, 0},
		'{1023, 1023, 1023, 1023, 1023, 1023},
		'{1023, 1023, 0, 0, 1023, 1023},
		'{1023, 1023, 1023, 1023, 1023, 1023},
		'{1023, 1023, 512, 1023, 1023, 1023},   // sample equal to the threshold
		'{1023, 1023, 513, 1023, 1023, 1023},   // just above the threshold: not seen
		'{1023, 0, 0, 1023, 1023, 1023},
		'{0, 0, 0, 0, 0, 1023},
		'{1023, 0, 0, 0, 0, 0},
		'{1023, 1023, 1023, 1023, 100, 400},
		'{1023, 1023, 1023, 0, 200, 1023},
		'{0, 1023, 0, 1023, 0, 1023},
		'{511, 512, 510, 1023, 1023, 1023},
		'{1023, 1023, 1023, 300, 0, 511}
	};

	// known flag, position, mask, count, pattern, direction; unknown rows go to the predictor
	localparam int ROW_WANT [NUM_ROWS][6] = '{
		'{1, 0, 0, 0, PAT_LOST, HDG_CENTER},
		'{1, 0, 'h3f, 6, PAT_CROSSING, HDG_CENTER},
		'{1, -16384, 'h01, 1, PAT_SHARP, HDG_LEFT},
		'{1, -16384, 0, 0, PAT_LOST, HDG_LEFT},
		'{1, 16384, 'h20, 1, PAT_SHARP, HDG_RIGHT},
		'{1, 16384, 0, 0, PAT_LOST, HDG_RIGHT},
		'{1, 0, 'h0c, 2, PAT_STRAIGHT, HDG_CENTER},
		'{1, 0, 0, 0, PAT_LOST, HDG_CENTER},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0}
	};

	// one scan waiting to be pushed, with its result where it is known by hand
	typedef struct {
		in_item_t  scan;
		bit        known;
		out_item_t want;
	} scan_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t item = '0;
	logic pop = 1'b0;
	logic empty;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state and its copy of the registers
	sample_t cfg_threshold = THRESHOLD_RESET;
	logic [2:0] cfg_crossing = CROSSING_RESET;
	logic [1:0] last_heading = HDG_CENTER;

	scan_entry_t scan_q [$];
	out_item_t expected_q [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int results_seen = 0;
	int cycle_count = 0;

	line_position_estimator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.pop       (pop),
		.empty     (empty),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(PERIOD_NS / 2) clk = ~clk;
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic in_item_t scan_of(int s0, int s1, int s2, int s3, int s4, int s5);
		in_item_t it;
		it.raw_0 = sample_t'(s0);
		it.raw_1 = sample_t'(s1);
		it.raw_2 = sample_t'(s2);
		it.raw_3 = sample_t'(s3);
		it.raw_4 = sample_t'(s4);
		it.raw_5 = sample_t'(s5);
		return it;
	endfunction

	function automatic out_item_t result_of(int pos, int mask, int cnt, logic [2:0] pat,
			logic [1:0] dir);
		out_item_t r;
		r.position = 16'(pos);
		r.active_mask = 6'(mask);
		r.active_count = 3'(cnt);
		r.pattern = pat;
		r.direction = dir;
		return r;
	endfunction

	// weighted centroid of the dark sensors, with the heading memory and grading
	function automatic out_item_t estimate_position(in_item_t scan);
		sample_t s [NUM_SENSORS];
		longint unity, wsum, tsum, inten, mag, quot, pos, amag;
		int cnt;
		logic [5:0] mask;
		logic [2:0] pat;
		out_item_t r;
		s = '{scan.raw_0, scan.raw_1, scan.raw_2, scan.raw_3, scan.raw_4, scan.raw_5};
		unity = longint'(1) << FRAC_BITS;
		wsum = 0;
		tsum = 0;
		cnt = 0;
		mask = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (s[i] <= cfg_threshold) begin
				inten = longint'(cfg_threshold) - longint'(s[i]);
				if (inten < 1)
					inten = 1;
				mask[i] = 1'b1;
				cnt++;
				wsum += SENSOR_WEIGHT[i] * inten;
				tsum += inten;
			end
		end
		if (cnt == 0) begin
			// line lost: hold the heading and report it at full scale
			if (last_heading == HDG_RIGHT)
				pos = unity;
			else if (last_heading == HDG_LEFT)
				pos = -unity;
			else
				pos = 0;
			pat = PAT_LOST;
		end else begin
			mag = (wsum < 0) ? -wsum : wsum;
			quot = (mag << FRAC_BITS) / (5 * tsum);
			pos = (wsum < 0) ? -quot : quot;
			if (pos > unity)
				pos = unity;
			if (pos < -unity)
				pos = -unity;
			// set the heading: left or right outside the dead band, center inside it
			if (10 * pos < -unity)
				last_heading = HDG_LEFT;
			else if (10 * pos > unity)
				last_heading = HDG_RIGHT;
			else
				last_heading = HDG_CENTER;
			amag = (pos < 0) ? -pos : pos;
			if (cnt >= cfg_crossing)
				pat = PAT_CROSSING;
			else if (4 * amag < unity)
				pat = PAT_STRAIGHT;
			else if (2 * amag < unity)
				pat = PAT_LIGHT;
			else if (4 * amag < 3 * unity)
				pat = PAT_MEDIUM;
			else
				pat = PAT_SHARP;
		end
		r.position = 16'(pos);
		r.active_mask = mask;
		r.active_count = 3'(cnt);
		r.pattern = pat;
		r.direction = last_heading;
		return r;
	endfunction

	function automatic sample_t dark_sample();
		return sample_t'($urandom_range(cfg_threshold, 0));
	endfunction

	function automatic sample_t light_sample();
		if (cfg_threshold == '1)
			return '1;
		return sample_t'($urandom_range(1023, cfg_threshold + 1));
	endfunction

	// random scan: in 45 of 100 cases a line under one to three adjacent sensors, the rest noise and corners
	function automatic in_item_t random_scan();
		int s [NUM_SENSORS];
		int kind, first, width;
		kind = $urandom_range(99, 0);
		first = $urandom_range(NUM_SENSORS - 1, 0);
		width = $urandom_range(3, 1);
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (kind < 45)
				s[i] = (i >= first && i < first + width) ? dark_sample() : light_sample();
			else if (kind < 65)
				s[i] = $urandom_range(1023, 0);
			else if (kind < 75)
				s[i] = light_sample();
			else if (kind < 85)
				s[i] = ($urandom_range(99, 0) < 85) ? dark_sample() : light_sample();
			else begin
				// hug the threshold
				s[i] = int'(cfg_threshold) + int'($urandom_range(2, 0)) - 1;
				if (s[i] < 0)
					s[i] = 0;
				if (s[i] > 1023)
					s[i] = 1023;
			end
		end
		return scan_of(s[0], s[1], s[2], s[3], s[4], s[5]);
	endfunction

	// write one register and mirror it in the predictor
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LINE_THRESHOLD)
			cfg_threshold = sample_t'(val);
		else
			cfg_crossing = val[2:0];
	endtask

	task automatic add_row(in_item_t scan, bit known, out_item_t want);
		scan_q.push_back('{scan: scan, known: known, want: want});
	endtask

	task automatic wait_idle();
		while (scan_q.size() != 0 || push || expected_q.size() != 0)
			@(posedge clk);
	endtask

	// sender: hold an item until taken, predict it on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin : send
			scan_entry_t taken;
			out_item_t predicted;
			if (push && !full) begin
				taken = scan_q.pop_front();
				predicted = estimate_position(item);
				expected_q.push_back(taken.known ? taken.want : predicted);
			end
			if (!push || !full) begin
				if (scan_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					push <= 1'b1;
					item <= scan_q[0].scan;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver: pop at random, check each item against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin : recv
			out_item_t want;
			if (pop && !empty) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("result %0d arrived with nothing expected", results_seen);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (result.position !== want.position ||
							result.active_mask !== want.active_mask ||
							result.active_count !== want.active_count ||
							result.pattern !== want.pattern ||
							result.direction !== want.direction) begin
						if (fail_count < MAX_REPORTS) begin
							$display("result %0d: expected pos %0d mask %h cnt %0d pat %0d dir %0d",
								results_seen, $signed(want.position), want.active_mask,
								want.active_count, want.pattern, want.direction);
							$display("result %0d: got pos %0d mask %h cnt %0d pat %0d dir %0d",
								results_seen, $signed(result.position), result.active_mask,
								result.active_count, result.pattern, result.direction);
						end
						fail_count++;
					end
				end
			end
			pop <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	initial begin : sequencer
		int val;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table at reset settings
		@(negedge clk);
		send_idle_pct = 37;
		recv_idle_pct = 66;
		for (int r = 0; r < NUM_ROWS; r++)
			add_row(scan_of(ROW_SCAN[r][0], ROW_SCAN[r][1], ROW_SCAN[r][2],
					ROW_SCAN[r][3], ROW_SCAN[r][4], ROW_SCAN[r][5]),
				ROW_WANT[r][0] != 0,
				result_of(ROW_WANT[r][1], ROW_WANT[r][2], ROW_WANT[r][3],
					3'(ROW_WANT[r][4]), 2'(ROW_WANT[r][5])));
		wait_idle();

		// random phases, each under its own settings and idling
		for (int p = 0; p < NUM_PHASES; p++) begin
			val = (PHASE_THR[p] == RANDOM_REG) ? $urandom_range(1023, 0) : PHASE_THR[p];
			write_reg(CFG_LINE_THRESHOLD, CFG_DATA_W'(val));
			val = (PHASE_CROSS[p] == RANDOM_REG) ? $urandom_range(1023, 0) : PHASE_CROSS[p];
			write_reg(CFG_CROSSING_MIN_ACTV, CFG_DATA_W'(val));
			@(negedge clk);
			if (p < 3) begin
				send_idle_pct = 37;
				recv_idle_pct = 66;
			end else if (p < 6) begin
				send_idle_pct = 66;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_SCANS; n++)
				add_row(random_scan(), 0, '0);
			wait_idle();
		end

		// catch stray results
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
